// File: hdl/tensor_permute_address_gen_defines.svh
// Assertion macros shared by the tensor permute address generator.
`ifndef TENSOR_PERMUTE_ADDRESS_GEN_DEFINES_SVH
`define TENSOR_PERMUTE_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define TPAG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define TPAG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tpag_pkg.sv
// Shared constants, types and command/status structs of the permute address generator.
package tpag_pkg;

  localparam int MAX_RANK   = 8;
  localparam int DIM_BITS   = 8;
  localparam int ADDR_BITS  = 32;
  localparam int IDX_W      = $clog2(MAX_RANK);
  localparam int ORDER_BITS = IDX_W;
  localparam int RANK_W     = 4;
  localparam int CNT_W      = ADDR_BITS + 1;
  localparam int DIMS_W     = MAX_RANK * DIM_BITS;
  localparam int ORDER_W    = MAX_RANK * ORDER_BITS;
  localparam int DATA_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [RANK_W-1:0]  RANK_RESET  = RANK_W'(1);
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(24'hFAC688);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK  = 2'd0,
    CFG_DIMS  = 2'd1,
    CFG_ORDER = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_PROD,
    ST_SIZE,
    ST_CORR,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             capture;
    logic             step;
    logic             use_hold;
    logic             prod_step;
    logic             size_load;
    logic             corr_step;
    logic [IDX_W-1:0] idx;
  } tpag_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] cfg_rank_m1;
    logic [IDX_W-1:0] held_rank_m1;
  } tpag_status_t;

endpackage

// File: hdl/tpag_if.sv
// Valid/ready stream interfaces for the element input and the offset output channels.
interface tpag_in_if import tpag_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic              first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

interface tpag_out_if import tpag_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] dest_offset;
  logic [DATA_W-1:0]    data_out;
  logic                 last;
  logic                 bad_config;

  modport source (output valid, output dest_offset, output data_out, output last,
                  output bad_config, input ready);
  modport sink   (input valid, input dest_offset, input data_out, input last,
                  input bad_config, output ready);
endinterface

// File: hdl/tpag_ctrl.sv
// Sequencer for stride setup and element issue, plus output valid tracking.
module tpag_ctrl import tpag_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_first_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  input  tpag_status_t status_i,
  output tpag_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             in_ready;
  tpag_cmd_t        cmd;

  assign slot_free = !out_valid_q || out_ready_i;

  // State, loop counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    in_ready = 1'b0;
    cmd      = '0;
    cmd.idx  = idx_q;
    unique case (state_q)
      ST_RUN: begin
        in_ready = slot_free;
        if (in_valid_i && slot_free) begin
          if (in_first_i) begin
            cmd.capture = 1'b1;
            idx_d       = status_i.cfg_rank_m1;
            state_d     = ST_PROD;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_PROD: begin
        cmd.prod_step = 1'b1;
        if (idx_q == '0) begin
          state_d = ST_SIZE;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      ST_SIZE: begin
        cmd.size_load = 1'b1;
        idx_d         = status_i.held_rank_m1;
        state_d       = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr_step = 1'b1;
        if (idx_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.step     = 1'b1;
          cmd.use_hold = 1'b1;
          state_d      = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Load on issue, drop once the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: hdl/tpag_dp.sv
// Datapath: config registers, stride setup arithmetic, index odometer and output register.
module tpag_dp import tpag_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [DATA_W-1:0]     in_value_i,
  input  tpag_cmd_t             cmd_i,
  output tpag_status_t          status_o,
  output logic [ADDR_BITS-1:0]  out_dest_offset_o,
  output logic [DATA_W-1:0]     out_data_o,
  output logic                  out_last_o,
  output logic                  out_bad_config_o
);

  localparam int PROD_W = CNT_W + DIM_BITS + 1;
  localparam int CMUL_W = ADDR_BITS + DIM_BITS;
  localparam logic [PROD_W-1:0] CAP = PROD_W'(1) << ADDR_BITS;

  // Clamp the rank register to 1..MAX_RANK and return it minus one
  function automatic logic [IDX_W-1:0] clamp_rank_m1(input logic [RANK_W-1:0] r);
    logic [IDX_W-1:0] m;
    if (r == '0) begin
      m = '0;
    end else if ({1'b0, r} > (RANK_W+1)'(MAX_RANK)) begin
      m = IDX_W'(MAX_RANK - 1);
    end else begin
      m = IDX_W'(r - RANK_W'(1));
    end
    return m;
  endfunction

  // Configuration registers
  logic [RANK_W-1:0]  rank_q;
  logic [DIMS_W-1:0]  dims_q;
  logic [ORDER_W-1:0] order_q;

  // Per-tensor state
  logic [IDX_W-1:0]     held_rank_m1_q;
  logic [DIM_BITS-1:0]  held_dm1_q [MAX_RANK];
  logic [IDX_W-1:0]     held_ord_q [MAX_RANK];
  logic                 order_bad_q;
  logic                 held_bad_q;
  logic [DATA_W-1:0]    value_hold_q;
  logic [CNT_W-1:0]     prod_q;
  logic                 over_q;
  logic [CNT_W-1:0]     run_q;
  logic [ADDR_BITS-1:0] acc_q;
  logic [ADDR_BITS-1:0] stride_q [MAX_RANK];
  logic [ADDR_BITS-1:0] step_q [MAX_RANK];
  logic [DIM_BITS-1:0]  index_q [MAX_RANK];
  logic [ADDR_BITS-1:0] offset_q;
  logic [CNT_W-1:0]     left_q;

  // Output register
  logic [ADDR_BITS-1:0] out_off_q;
  logic [DATA_W-1:0]    out_data_q;
  logic                 out_last_q;
  logic                 out_bad_q;

  // Combinational helpers
  logic [IDX_W-1:0]     cfg_rank_m1;
  logic [DIM_BITS-1:0]  cfg_dm1 [MAX_RANK];
  logic [IDX_W-1:0]     cfg_ord [MAX_RANK];
  logic                 cfg_order_bad;
  logic [DIM_BITS:0]    cur_dim;
  logic [DIM_BITS-1:0]  nd_m1;
  logic [DIM_BITS:0]    new_dim;
  logic [PROD_W-1:0]    prod_mul;
  logic [PROD_W-1:0]    run_mul;
  logic [CMUL_W-1:0]    corr_mul;
  logic                 adv_found;
  logic [IDX_W-1:0]     adv_sel;
  logic [ADDR_BITS-1:0] adv_offset;
  logic [DIM_BITS-1:0]  index_adv [MAX_RANK];
  logic [DATA_W-1:0]    step_data;

  assign cfg_rank_m1 = clamp_rank_m1(rank_q);

  // Unpack fields and check that the order is a permutation of the used axes
  always_comb begin
    cfg_order_bad = 1'b0;
    for (int a = 0; a < MAX_RANK; a++) begin
      cfg_dm1[a] = dims_q[a*DIM_BITS +: DIM_BITS];
      cfg_ord[a] = order_q[a*ORDER_BITS +: ORDER_BITS];
    end
    for (int a = 0; a < MAX_RANK; a++) begin
      if (IDX_W'(a) <= cfg_rank_m1) begin
        if (cfg_ord[a] > cfg_rank_m1) begin
          cfg_order_bad = 1'b1;
        end
        for (int b = 0; b < a; b++) begin
          if (cfg_ord[b] == cfg_ord[a]) begin
            cfg_order_bad = 1'b1;
          end
        end
      end
    end
  end

  // Setup arithmetic: element count, running destination stride, step correction
  always_comb begin
    nd_m1 = '0;
    for (int k = 0; k < MAX_RANK; k++) begin
      if (IDX_W'(k) <= held_rank_m1_q && held_ord_q[k] == cmd_i.idx) begin
        nd_m1 = held_dm1_q[k];
      end
    end
    cur_dim  = {1'b0, held_dm1_q[cmd_i.idx]} + (DIM_BITS+1)'(1);
    new_dim  = {1'b0, nd_m1} + (DIM_BITS+1)'(1);
    prod_mul = PROD_W'(prod_q) * PROD_W'(cur_dim);
    run_mul  = PROD_W'(run_q) * PROD_W'(new_dim);
    corr_mul = CMUL_W'(held_dm1_q[cmd_i.idx]) * CMUL_W'(stride_q[cmd_i.idx]);
  end

  // Odometer: the highest used axis not at its end advances, axes after it wrap
  always_comb begin
    adv_found = 1'b0;
    adv_sel   = '0;
    for (int j = 0; j < MAX_RANK; j++) begin
      if (IDX_W'(j) <= held_rank_m1_q && index_q[j] != held_dm1_q[j]) begin
        adv_found = 1'b1;
        adv_sel   = IDX_W'(j);
      end
    end
    adv_offset = adv_found ? (offset_q + step_q[adv_sel]) : '0;
    for (int j = 0; j < MAX_RANK; j++) begin
      index_adv[j] = index_q[j];
      if (IDX_W'(j) <= held_rank_m1_q) begin
        if (adv_found && adv_sel == IDX_W'(j)) begin
          index_adv[j] = index_q[j] + DIM_BITS'(1);
        end else if (!adv_found || IDX_W'(j) > adv_sel) begin
          index_adv[j] = '0;
        end
      end
    end
  end

  assign step_data = cmd_i.use_hold ? value_hold_q : in_value_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RANK_RESET;
      dims_q  <= '0;
      order_q <= ORDER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RANK:  rank_q  <= cfg_wdata_i[RANK_W-1:0];
        CFG_DIMS:  dims_q  <= cfg_wdata_i[DIMS_W-1:0];
        CFG_ORDER: order_q <= cfg_wdata_i[ORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tensor control state: rank, bad flag, count, offset and indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_rank_m1_q <= '0;
      held_bad_q     <= 1'b0;
      left_q         <= '0;
      offset_q       <= '0;
      for (int j = 0; j < MAX_RANK; j++) begin
        index_q[j] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        held_rank_m1_q <= cfg_rank_m1;
        offset_q       <= '0;
        for (int j = 0; j < MAX_RANK; j++) begin
          index_q[j] <= '0;
        end
      end
      if (cmd_i.size_load) begin
        left_q     <= over_q ? CAP[CNT_W-1:0] : prod_q;
        held_bad_q <= order_bad_q || over_q;
      end
      if (cmd_i.step && left_q != '0) begin
        left_q <= left_q - CNT_W'(1);
        if (!held_bad_q) begin
          offset_q <= adv_offset;
          for (int j = 0; j < MAX_RANK; j++) begin
            index_q[j] <= index_adv[j];
          end
        end
      end
    end
  end

  // Setup payload and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      order_bad_q  <= cfg_order_bad;
      value_hold_q <= in_value_i;
      prod_q       <= CNT_W'(1);
      over_q       <= 1'b0;
      run_q        <= CNT_W'(1);
      acc_q        <= '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        held_ord_q[k] <= cfg_ord[k];
        held_dm1_q[k] <= (IDX_W'(k) <= cfg_rank_m1) ? cfg_dm1[k] : '0;
      end
    end
    if (cmd_i.prod_step) begin
      if (!over_q) begin
        if (prod_mul > CAP) begin
          over_q <= 1'b1;
        end else begin
          prod_q <= prod_mul[CNT_W-1:0];
        end
      end
      run_q <= run_mul[CNT_W-1:0];
      for (int k = 0; k < MAX_RANK; k++) begin
        if (IDX_W'(k) <= held_rank_m1_q && held_ord_q[k] == cmd_i.idx) begin
          stride_q[k] <= run_q[ADDR_BITS-1:0];
        end
      end
    end
    if (cmd_i.corr_step) begin
      step_q[cmd_i.idx] <= stride_q[cmd_i.idx] - acc_q;
      acc_q             <= acc_q + corr_mul[ADDR_BITS-1:0];
    end
    if (cmd_i.step) begin
      out_data_q <= step_data;
      if (left_q == '0) begin
        out_off_q  <= '0;
        out_last_q <= 1'b0;
        out_bad_q  <= 1'b0;
      end else begin
        out_off_q  <= held_bad_q ? '0 : offset_q;
        out_last_q <= (left_q == CNT_W'(1));
        out_bad_q  <= held_bad_q;
      end
    end
  end

  assign status_o.cfg_rank_m1  = cfg_rank_m1;
  assign status_o.held_rank_m1 = held_rank_m1_q;

  assign out_dest_offset_o = out_off_q;
  assign out_data_o        = out_data_q;
  assign out_last_o        = out_last_q;
  assign out_bad_config_o  = out_bad_q;

endmodule

// File: hdl/tensor_permute_address_gen.sv
// Top level of the tensor axis permute address generator.
// An element without the first flag is registered in the cycle after acceptance, one per cycle while output is taken.
// A first element runs stride setup: a product loop, a size load and a correction loop
// through one shared sequencer before its result is registered; input is held off meanwhile.
// Reset leaves rank 1, all dims 1 and the identity order; elements before a first give zero offsets and flags.
`include "tensor_permute_address_gen_defines.svh"

module tensor_permute_address_gen import tpag_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tpag_in_if.sink               in_if,
  tpag_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  tpag_cmd_t    cmd;
  tpag_status_t status;

  // Sequencer
  tpag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_first_i  (in_if.first),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  tpag_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_value_i        (in_if.value),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_dest_offset_o (out_if.dest_offset),
    .out_data_o        (out_if.data_out),
    .out_last_o        (out_if.last),
    .out_bad_config_o  (out_if.bad_config)
  );

  // A first element blocks input for the setup that follows it
  `TPAG_ASSERT_NXT(a_first_stalls, in_if.valid && in_if.ready && in_if.first, !in_if.ready, "input taken during stride setup")

  // A bad configuration never shows a nonzero offset
  `TPAG_ASSERT_IMP(a_bad_zero_offset, out_if.valid && out_if.bad_config, out_if.dest_offset == '0, "nonzero offset with bad configuration")

  // Element issue never overlaps a setup command
  `TPAG_ASSERT_IMP(a_issue_excl, cmd.step, !(cmd.prod_step || cmd.size_load || cmd.corr_step || cmd.capture), "element issued during setup")

endmodule

// File: tb/sv/tb_tensor_permute_address_gen.sv
// Self-checking testbench for the tensor permute address generator.
module tb_tensor_permute_address_gen import tpag_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES  = 4 * MAX_RANK + 8;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    logic [ADDR_BITS-1:0] offset;
    logic [DATA_W-1:0]    data;
    logic                 last;
    logic                 bad;
  } elem_result_t;

  typedef enum int unsigned {RX_STREAM, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tpag_in_if  elem_in ();
  tpag_out_if offset_out ();

  tensor_permute_address_gen uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (elem_in),
    .out_if      (offset_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow of the configuration registers
  logic [RANK_W-1:0]  cfg_rank;
  logic [DIMS_W-1:0]  cfg_dims;
  logic [ORDER_W-1:0] cfg_order;

  // Tensor state latched at the first element, plus the odometer
  int unsigned          lat_rank;
  logic [DIM_BITS:0]    lat_dim [MAX_RANK];
  logic                 lat_bad;
  logic [DIM_BITS-1:0]  odo_idx [MAX_RANK];
  logic [ADDR_BITS-1:0] odo_stride [MAX_RANK];
  logic [ADDR_BITS-1:0] odo_offset;
  logic [CNT_W-1:0]     remaining;

  elem_result_t awaited_elems [$];
  int unsigned  mismatches;
  int unsigned  items_sent;
  int unsigned  burst_left;
  int unsigned  cycles;
  logic         offering;
  logic         rx_hold;
  event         start_rx_hold;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Latch sizes, check the order and build the per-axis destination strides
  function automatic void latch_tensor_strides();
    int unsigned           r;
    logic [ORDER_BITS-1:0] place [MAX_RANK];
    longint unsigned       new_dim [MAX_RANK];
    longint unsigned       place_stride [MAX_RANK];
    bit                    taken [MAX_RANK];
    bit                    bad;
    bit                    over;
    longint unsigned       cap;
    longint unsigned       prod;
    r = 32'(cfg_rank);
    if (r == 0) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    lat_rank = r;
    cap = 64'd1 << ADDR_BITS;
    prod = 1;
    bad = 1'b0;
    over = 1'b0;
    for (int k = 0; k < MAX_RANK; k++) begin
      lat_dim[k] = (k < r) ?
                   ({1'b0, cfg_dims[k*DIM_BITS +: DIM_BITS]} + (DIM_BITS+1)'(1)) :
                   (DIM_BITS+1)'(1);
      new_dim[k] = 1;
      place_stride[k] = 0;
      odo_idx[k] = '0;
      odo_stride[k] = '0;
      taken[k] = 1'b0;
    end
    for (int k = 0; k < r; k++) begin
      place[k] = cfg_order[k*ORDER_BITS +: ORDER_BITS];
      if (place[k] >= r || taken[place[k]]) bad = 1'b1;
      else taken[place[k]] = 1'b1;
      if (!over) begin
        if (prod > cap / lat_dim[k]) over = 1'b1;
        else prod *= lat_dim[k];
      end
    end
    if (over) begin
      bad = 1'b1;
      prod = cap;
    end
    lat_bad = bad;
    remaining = CNT_W'(prod);
    odo_offset = '0;
    if (bad) return;
    for (int k = 0; k < r; k++) new_dim[place[k]] = lat_dim[k];
    place_stride[r-1] = 1;
    for (int k = r - 1; k > 0; k--) place_stride[k-1] = place_stride[k] * new_dim[k];
    for (int k = 0; k < r; k++) odo_stride[k] = ADDR_BITS'(place_stride[place[k]]);
  endfunction

  // Advance the per-axis indices, last axis fastest, and track the offset
  function automatic void step_odometer();
    for (int j = int'(lat_rank) - 1; j >= 0; j--) begin
      if (odo_idx[j] + 1 >= lat_dim[j]) begin
        odo_idx[j] = '0;
        odo_offset = odo_offset - (lat_dim[j] - 1) * odo_stride[j];
      end else begin
        odo_idx[j]++;
        odo_offset = odo_offset + odo_stride[j];
        break;
      end
    end
  endfunction

  // Work out the result of one accepted element and queue it
  function automatic void compute_dest_offset(input logic [DATA_W-1:0] v, input logic f);
    elem_result_t res;
    if (f) latch_tensor_strides();
    res.data = v;
    if (remaining == 0) begin
      res.offset = '0;
      res.last = 1'b0;
      res.bad = 1'b0;
    end else begin
      res.offset = lat_bad ? '0 : odo_offset;
      res.last = (remaining == 1);
      res.bad = lat_bad;
      remaining--;
      if (!lat_bad) step_odometer();
    end
    awaited_elems.push_back(res);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly random data, now and then all zeros or all ones
  function automatic logic [DATA_W-1:0] element_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return {DATA_W{1'b1}};
      default: return rand64();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    elem_result_t want;
    if (rst_ni && offset_out.valid && offset_out.ready) begin
      if (awaited_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected result: offset %0h data %0h last %0b bad %0b",
                                  offset_out.dest_offset, offset_out.data_out,
                                  offset_out.last, offset_out.bad_config));
      end else begin
        want = awaited_elems.pop_front();
        if (offset_out.dest_offset !== want.offset || offset_out.data_out !== want.data ||
            offset_out.last !== want.last || offset_out.bad_config !== want.bad) begin
          report_mismatch($sformatf(
            "expected offset %0h data %0h last %0b bad %0b, got %0h %0h %0b %0b",
            want.offset, want.data, want.last, want.bad, offset_out.dest_offset,
            offset_out.data_out, offset_out.last, offset_out.bad_config));
        end
      end
    end
  end

  // Receiver ready: a stall mode that changes now and then, overridden by a hold
  initial begin : rx_ready_drive
    rx_mode_e    mode;
    int unsigned mode_left;
    offset_out.ready = 1'b0;
    mode = RX_STREAM;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (rx_hold) offset_out.ready <= 1'b0;
      else begin
        case (mode)
          RX_STREAM: offset_out.ready <= 1'b1;
          RX_LIGHT:  offset_out.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   offset_out.ready <= 1'($urandom_range(0, 1));
          default:   offset_out.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Long receiver hold-off, counted here
  initial begin : rx_hold_ctl
    int unsigned hold_count;
    rx_hold = 1'b0;
    forever begin
      @(start_rx_hold);
      @(posedge clk_i);
      rx_hold = 1'b1;
      hold_count = 0;
      while (hold_count < RX_HOLD_CYCLES) begin
        @(posedge clk_i);
        hold_count++;
      end
      rx_hold = 1'b0;
    end
  end

  // Lower valid and let a step pass so no other drive lands in the same step
  task automatic drop_valid();
    if (offering) begin
      elem_in.valid <= 1'b0;
      offering = 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (awaited_elems.size() != 0) @(negedge clk_i);
  endtask

  // Offer one element in bursts with random gaps, hold it until accepted
  task automatic send_element(input logic [DATA_W-1:0] v, input logic f);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        drop_valid();
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    elem_in.valid <= 1'b1;
    elem_in.value <= v;
    elem_in.first <= f;
    offering = 1'b1;
    do @(posedge clk_i); while (!elem_in.ready);
    compute_dest_offset(v, f);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tensor(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_element(element_value(), i == 0);
  endtask

  // Write all three registers once the block has drained
  task automatic configure(input logic [RANK_W-1:0] rk, input logic [DIMS_W-1:0] dm,
                           input logic [ORDER_W-1:0] od);
    logic [CFG_DATA_W-1:0] word;
    wait_drained();
    word = rand64();
    word[RANK_W-1:0] = rk;
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_RANK;
    cfg_wdata_i <= word;
    cfg_rank = rk;
    @(negedge clk_i);
    cfg_index_i <= CFG_DIMS;
    cfg_wdata_i <= dm;
    cfg_dims = dm;
    @(negedge clk_i);
    word = rand64();
    word[ORDER_W-1:0] = od;
    cfg_index_i <= CFG_ORDER;
    cfg_wdata_i <= word;
    cfg_order = od;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Elements before any tensor, then a one-element tensor on reset settings
  task automatic test_before_first();
    send_element('0, 1'b0);
    send_element({DATA_W{1'b1}}, 1'b0);
    send_element(rand64(), 1'b1);
    send_element(rand64(), 1'b0);
  endtask

  // Rank zero acts as one, rank above the maximum acts as the maximum
  task automatic test_rank_clamp();
    configure(4'd0, {56'hA5A5A5A5A5A5A5, 8'd2}, ORDER_RESET);
    send_tensor(3);
    configure(4'd15, {8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0},
              {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7});
    send_tensor(3);
  endtask

  // Order entry beyond the rank, then two equal entries
  task automatic test_bad_order();
    configure(4'd3, {40'h0, 8'd1, 8'd0, 8'd1}, {15'd0, 3'd0, 3'd3, 3'd1});
    send_tensor(4);
    configure(4'd3, {40'h0, 8'd1, 8'd0, 8'd1}, {15'd0, 3'd0, 3'd1, 3'd1});
    send_tensor(1);
  endtask

  // Size above capacity, size at capacity, and a stride that wraps to zero
  task automatic test_capacity();
    configure(4'd5, {24'h0, 40'hFF_FFFF_FFFF}, ORDER_RESET);
    send_tensor(1);
    configure(4'd4, {32'h0, 32'hFFFF_FFFF}, {12'd0, 3'd0, 3'd1, 3'd2, 3'd3});
    send_tensor(2);
    configure(4'd5, {24'h0, 8'd0, 32'hFFFF_FFFF}, {9'd0, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1});
    send_tensor(2);
  endtask

  // Restart mid-tensor, then stray elements after the tensor ends
  task automatic test_restart();
    configure(4'd2, {48'h0, 8'd1, 8'd1}, {18'd0, 3'd0, 3'd1});
    send_tensor(2);
    send_tensor(4);
    send_element(element_value(), 1'b0);
  endtask

  // Fill the block while the receiver holds off
  task automatic test_output_backpressure();
    configure(4'd3, {40'h0, 8'd3, 8'd3, 8'd3}, {15'd0, 3'd0, 3'd2, 3'd1});
    -> start_rx_hold;
    send_tensor(64);
  endtask

  // Full-width axis, so the index wraps at its top value
  task automatic test_wide_axis();
    configure(4'd2, {48'h0, 8'hFF, 8'h01}, {18'd0, 3'd0, 3'd1});
    send_tensor(512);
  endtask

  // Random settings and tensors: mostly complete ones, some cut short or bad
  task automatic test_random_tensors(input int unsigned n_items);
    int unsigned           goal;
    int unsigned           raw_rank;
    int unsigned           r_eff;
    int unsigned           elems;
    int unsigned           sz;
    int unsigned           j;
    int unsigned           victim;
    logic [DIMS_W-1:0]     dims;
    logic [ORDER_W-1:0]    order;
    logic [ORDER_BITS-1:0] place [MAX_RANK];
    logic [ORDER_BITS-1:0] swap;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      case ($urandom_range(0, 19))
        0:       raw_rank = 0;
        1:       raw_rank = $urandom_range(MAX_RANK + 1, 15);
        default: raw_rank = $urandom_range(1, MAX_RANK);
      endcase
      r_eff = (raw_rank == 0) ? 1 : ((raw_rank > MAX_RANK) ? MAX_RANK : raw_rank);
      // Small sizes on the used axes, garbage above them
      dims = rand64();
      order = ORDER_W'($urandom());
      elems = 1;
      for (int k = 0; k < r_eff; k++) begin
        sz = $urandom_range(1, 4);
        if (elems * sz > 64) sz = 1;
        elems *= sz;
        dims[k*DIM_BITS +: DIM_BITS] = DIM_BITS'(sz - 1);
      end
      // Shuffle a valid permutation into the used order fields
      for (int k = 0; k < MAX_RANK; k++) place[k] = ORDER_BITS'(k);
      for (int k = r_eff - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        swap = place[k];
        place[k] = place[j];
        place[j] = swap;
      end
      for (int k = 0; k < r_eff; k++) order[k*ORDER_BITS +: ORDER_BITS] = place[k];
      // Now and then break the permutation
      if ($urandom_range(0, 9) == 0) begin
        victim = $urandom_range(0, r_eff - 1);
        if (r_eff == MAX_RANK || (r_eff > 1 && $urandom_range(0, 1) == 1))
          order[victim*ORDER_BITS +: ORDER_BITS] = place[(victim + 1) % r_eff];
        else
          order[victim*ORDER_BITS +: ORDER_BITS] = ORDER_BITS'($urandom_range(r_eff, 7));
      end
      configure(RANK_W'(raw_rank), dims, order);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: send_tensor((elems > 1) ? $urandom_range(1, elems - 1) : 1);
          1: begin
            send_tensor(elems);
            repeat ($urandom_range(1, 3)) send_element(element_value(), 1'b0);
          end
          default: send_tensor(elems);
        endcase
      end
    end
  endtask

  // Reset, run the tests in turn, drain and report
  initial begin : main_seq
    elem_in.valid = 1'b0;
    elem_in.value = '0;
    elem_in.first = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_RANK;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    cfg_rank = RANK_RESET;
    cfg_dims = '0;
    cfg_order = ORDER_RESET;
    lat_rank = 0;
    lat_bad = 1'b0;
    odo_offset = '0;
    remaining = '0;
    for (int k = 0; k < MAX_RANK; k++) begin
      lat_dim[k] = '0;
      odo_idx[k] = '0;
      odo_stride[k] = '0;
    end
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    offering = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_before_first();
    test_rank_clamp();
    test_bad_order();
    test_capacity();
    test_restart();
    test_output_backpressure();
    test_wide_axis();
    test_random_tensors(650);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && awaited_elems.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
